@@ src/wcs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wcs_pkg;

    // Field widths
    localparam int CV_W      = 15;
    localparam int BIAS_K_W  = 14;
    localparam int RANGE_K_W = 14;
    localparam int STEP_K_W  = 11;
    localparam int CFG_W     = 14;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 15;
    localparam int LEVEL_W   = 4;

    // Stream payload widths (byte padded)
    localparam int S_DATA_W = 112;
    localparam int M_DATA_W = 24;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_KNOB  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_KNOB = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_KNOB  = 2'd2;

    // Register reset values
    localparam logic signed [BIAS_K_W-1:0] BIAS_KNOB_RST  = 14'sd1000;
    localparam logic [RANGE_K_W-1:0]       RANGE_KNOB_RST = 14'd3000;
    localparam logic signed [STEP_K_W-1:0] STEP_KNOB_RST  = 11'sd417;

    // Limits and thresholds, mV
    localparam logic signed [15:0] VOLT_MAX   = 16'sd10000;
    localparam logic signed [15:0] VOLT_MIN   = -16'sd10000;
    localparam logic [16:0]        RANGE_MAX  = 17'd10000;
    localparam logic signed [14:0] STEP_MAX   = 15'sd5000;
    localparam logic signed [14:0] STEP_MIN   = -15'sd5000;
    localparam logic signed [CV_W-1:0] TRIG_ON  = 15'sd1000;
    localparam logic signed [CV_W-1:0] TRIG_OFF = 15'sd100;
    localparam logic signed [CV_W-1:0] RST_ON   = 15'sd1000;
    localparam logic signed [14:0] RV_RST     = 15'sd1000;

    // step_cv/5 rounding: floor((2*cv + 40005) / 10) - 4000
    localparam logic signed [17:0] CV5_OFFSET = 18'sd40005;
    localparam logic [32:0]        DIV10_MUL  = 33'd52429;   // 2^19 / 10, rounded up
    localparam logic signed [13:0] CV5_BIAS   = 14'sd4000;

    // Bar level
    localparam logic [LEVEL_W-1:0] LEVEL_MIN = 4'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 4'd10;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture input request
        logic ctrl;   // bias, range, step_cv scaling
        logic step;   // step, window gates, delta
        logic upd;    // trigger / reset state update
        logic num;    // bar numerator
        logic mul;    // times 11, divider init
        logic div;    // divider iteration
        logic out;    // load result register
    } wcs_cmd_t;

endpackage

`default_nettype wire

@@ src/wcs_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wcs_ctrl
    import wcs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    input  wire logic      div_done,
    output wcs_cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CTRL = 3'd1;
    localparam logic [2:0] ST_STEP = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_NUM  = 3'd4;
    localparam logic [2:0] ST_MUL  = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CTRL;
                end
            end
            ST_CTRL: begin
                cmd.ctrl   = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                cmd.step   = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd    = 1'b1;
                state_next = ST_NUM;
            end
            ST_NUM: begin
                cmd.num    = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div = 1'b1;
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait for a free result slot
                if (!m_valid_reg || m_tready) begin
                    cmd.out    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid flag
    always_comb begin
        if (cmd.out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ src/wcs_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wcs_dp
    import wcs_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // configuration
    input  wire logic                        cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]        cfg_addr,
    input  wire logic [CFG_W-1:0]            cfg_wdata,
    // request fields
    input  wire logic signed [CV_W-1:0]      comparator_in,
    input  wire logic                        comparator_plugged,
    input  wire logic signed [CV_W-1:0]      bias_cv,
    input  wire logic signed [CV_W-1:0]      range_cv,
    input  wire logic signed [CV_W-1:0]      step_cv,
    input  wire logic signed [CV_W-1:0]      invert_cv,
    input  wire logic signed [CV_W-1:0]      trigger_cv,
    input  wire logic signed [CV_W-1:0]      reset_cv,
    // control
    input  wire wcs_cmd_t                    cmd,
    output logic                             div_done,
    // result fields
    output logic                             up_gate,
    output logic                             down_gate,
    output logic signed [OUT_W-1:0]          stepper_out,
    output logic [LEVEL_W-1:0]               bar_level
);

    // Configuration registers
    logic signed [BIAS_K_W-1:0] bias_knob_reg;
    logic [RANGE_K_W-1:0]       range_knob_reg;
    logic signed [STEP_K_W-1:0] step_knob_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_knob_reg  <= BIAS_KNOB_RST;
            range_knob_reg <= RANGE_KNOB_RST;
            step_knob_reg  <= STEP_KNOB_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_BIAS_KNOB:  bias_knob_reg  <= cfg_wdata;
                REG_RANGE_KNOB: range_knob_reg <= cfg_wdata;
                REG_STEP_KNOB:  step_knob_reg  <= cfg_wdata[STEP_K_W-1:0];
                default: ;
            endcase
        end
    end

    // Captured request
    logic signed [CV_W-1:0] cin_reg, bias_cv_reg, range_cv_reg, step_cv_reg;
    logic signed [CV_W-1:0] invert_cv_reg, trigger_cv_reg, reset_cv_reg;
    logic                   plugged_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cin_reg        <= comparator_in;
            plugged_reg    <= comparator_plugged;
            bias_cv_reg    <= bias_cv;
            range_cv_reg   <= range_cv;
            step_cv_reg    <= step_cv;
            invert_cv_reg  <= invert_cv;
            trigger_cv_reg <= trigger_cv;
            reset_cv_reg   <= reset_cv;
        end
    end

    // Effective bias and range, step_cv / 5 via reciprocal multiply
    logic signed [15:0] bias_sum;
    logic signed [14:0] bias_clamp;
    logic signed [16:0] range_sum;
    logic [16:0]        range_abs;
    logic [13:0]        range_clamp;
    logic signed [17:0] cv_x;
    logic [32:0]        cv_prod;
    logic signed [14:0] bias_reg;
    logic [13:0]        range_reg;
    logic [12:0]        q10_reg;

    assign bias_sum = {{2{bias_knob_reg[BIAS_K_W-1]}}, bias_knob_reg}
                    + {bias_cv_reg[CV_W-1], bias_cv_reg};
    always_comb begin
        if (bias_sum > VOLT_MAX) begin
            bias_clamp = VOLT_MAX[14:0];
        end else if (bias_sum < VOLT_MIN) begin
            bias_clamp = VOLT_MIN[14:0];
        end else begin
            bias_clamp = bias_sum[14:0];
        end
    end

    assign range_sum = $signed({3'b000, range_knob_reg})
                     + {{2{range_cv_reg[CV_W-1]}}, range_cv_reg};
    assign range_abs   = range_sum[16] ? 17'(-range_sum) : 17'(range_sum);
    assign range_clamp = (range_abs > RANGE_MAX) ? RANGE_MAX[13:0] : range_abs[13:0];

    assign cv_x    = {{2{step_cv_reg[CV_W-1]}}, step_cv_reg, 1'b0} + CV5_OFFSET;
    assign cv_prod = {16'd0, cv_x[16:0]} * DIV10_MUL;

    always_ff @(posedge aclk) begin
        if (cmd.ctrl) begin
            bias_reg  <= bias_clamp;
            range_reg <= range_clamp;
            q10_reg   <= cv_prod[31:19];
        end
    end

    // Step, window gates and position delta
    logic signed [13:0] cv5;
    logic signed [14:0] step_sum;
    logic signed [13:0] step_clamp;
    logic signed [13:0] step_eff;
    logic signed [17:0] two_c;
    logic signed [17:0] two_bias;
    logic signed [17:0] hi_edge, lo_edge;
    logic               up_c, dn_c;
    logic signed [14:0] corr;
    logic signed [14:0] delta_c;
    logic signed [14:0] rv_reg;
    logic signed [14:0] delta_reg;
    logic               up_reg, dn_reg;

    assign cv5      = $signed({1'b0, q10_reg}) - CV5_BIAS;
    assign step_sum = {{4{step_knob_reg[STEP_K_W-1]}}, step_knob_reg}
                    + {cv5[13], cv5};
    always_comb begin
        if (step_sum > STEP_MAX) begin
            step_clamp = STEP_MAX[13:0];
        end else if (step_sum < STEP_MIN) begin
            step_clamp = STEP_MIN[13:0];
        end else begin
            step_clamp = step_sum[13:0];
        end
    end
    assign step_eff = (invert_cv_reg > 15'sd0) ? 14'(-step_clamp) : step_clamp;

    assign two_c    = plugged_reg ? {{2{cin_reg[CV_W-1]}}, cin_reg, 1'b0}
                                  : {{2{rv_reg[14]}}, rv_reg, 1'b0};
    assign two_bias = {{2{bias_reg[14]}}, bias_reg, 1'b0};
    assign hi_edge  = two_bias + $signed({4'b0000, range_reg});
    assign lo_edge  = two_bias - $signed({4'b0000, range_reg});
    assign up_c     = (two_c >= hi_edge);
    assign dn_c     = !up_c && (two_c <= lo_edge);

    always_comb begin
        if (plugged_reg) begin
            corr = '0;
        end else if (up_c) begin
            corr = -$signed({1'b0, range_reg});
        end else if (dn_c) begin
            corr = $signed({1'b0, range_reg});
        end else begin
            corr = '0;
        end
    end
    assign delta_c = (corr == 15'sd0) ? {step_eff[13], step_eff} : corr;

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            up_reg    <= up_c;
            dn_reg    <= dn_c;
            delta_reg <= delta_c;
        end
    end

    // Trigger edge, reset and hold
    logic signed [15:0] rv_sum;
    logic signed [14:0] rv_step;
    logic               trig_rise, trig_fall, rst_on;
    logic               th_reg, th_next;
    logic signed [14:0] rv_t, held_t;
    logic signed [14:0] rv_next, held_next;
    logic signed [14:0] held_reg;

    assign rv_sum = {rv_reg[14], rv_reg} + {delta_reg[14], delta_reg};
    always_comb begin
        if (rv_sum > VOLT_MAX) begin
            rv_step = VOLT_MAX[14:0];
        end else if (rv_sum < VOLT_MIN) begin
            rv_step = VOLT_MIN[14:0];
        end else begin
            rv_step = rv_sum[14:0];
        end
    end

    assign trig_rise = !th_reg && (trigger_cv_reg > TRIG_ON);
    assign trig_fall = th_reg && (trigger_cv_reg < TRIG_OFF);
    assign rst_on    = (reset_cv_reg >= RST_ON);

    always_comb begin
        th_next = th_reg;
        rv_t    = rv_reg;
        held_t  = held_reg;
        if (trig_rise) begin
            th_next = 1'b1;
            rv_t    = rv_step;
            held_t  = rv_step;
        end else if (trig_fall) begin
            th_next = 1'b0;
        end
        rv_next   = rv_t;
        held_next = held_t;
        if (rst_on) begin
            held_next = bias_reg;
            rv_next   = plugged_reg ? 15'sd0 : bias_reg;
        end else if (!th_next) begin
            held_next = rv_t;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            th_reg   <= 1'b0;
            rv_reg   <= RV_RST;
            held_reg <= '0;
        end else if (cmd.upd) begin
            th_reg   <= th_next;
            rv_reg   <= rv_next;
            held_reg <= held_next;
        end
    end

    // Bar numerator n = 2*(value - bias) + range
    logic signed [15:0] rv_diff;
    logic signed [17:0] n_c;
    logic               n_pos_reg;
    logic [15:0]        n_reg;

    assign rv_diff = {rv_reg[14], rv_reg} - {bias_reg[14], bias_reg};
    assign n_c     = {rv_diff[15], rv_diff, 1'b0} + $signed({4'b0000, range_reg});

    always_ff @(posedge aclk) begin
        if (cmd.num) begin
            n_pos_reg <= !n_c[17] && (n_c != 18'sd0);
            n_reg     <= n_c[15:0];
        end
    end

    // Divider: count subtractions of 2*range from 11*n, capped at ten
    logic [19:0]        num11;
    logic [14:0]        two_r;
    logic [19:0]        rem_reg;
    logic [LEVEL_W-1:0] q_reg;
    logic               fits;

    assign num11 = {1'b0, n_reg, 3'b000} + {3'b000, n_reg, 1'b0} + {4'b0000, n_reg};
    assign two_r = {range_reg, 1'b0};
    assign fits  = (rem_reg >= {5'd0, two_r}) && (q_reg != LEVEL_MAX);
    assign div_done = !fits;

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            rem_reg <= (n_pos_reg && (range_reg != '0)) ? num11 : '0;
            q_reg   <= '0;
        end else if (cmd.div && fits) begin
            rem_reg <= rem_reg - {5'd0, two_r};
            q_reg   <= q_reg + 4'd1;
        end
    end

    // Result register
    logic [LEVEL_W-1:0] level_c;

    always_comb begin
        if (range_reg == '0) begin
            level_c = n_pos_reg ? LEVEL_MAX : LEVEL_MIN;
        end else if (q_reg == '0) begin
            level_c = LEVEL_MIN;
        end else begin
            level_c = q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out) begin
            up_gate     <= up_reg;
            down_gate   <= dn_reg;
            stepper_out <= held_reg;
            bar_level   <= level_c;
        end
    end

endmodule

`default_nettype wire

@@ src/window_comparator_stepper.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Bus                  Contents
// s_        in   s_tdata[111:0]       control-voltage sample set
//                s_tuser[0]           comparator_plugged
// m_        out  m_tdata[23:0]        gates, held output, bar level
// cfg_      in   cfg_wr_en/addr/wdata knob registers, write only
//
// Each request passes through the accepting step, six fixed steps and the
// bar-level divider, which subtracts 2*range from 11*n repeatedly, at most
// ten subtractions. A new request is taken only when the previous one has
// reached the result register. Reset (aresetn low, synchronous) restores
// the knob defaults and the stepper state. A stalled result holds the
// controller in its final step; the result register is loaded as soon as
// it is free or being taken.

module window_comparator_stepper
    import wcs_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [CFG_W-1:0]       cfg_wdata,
    // request channel
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [14:0] comparator_in, [29:15] bias_cv, [44:30] range_cv, [59:45] step_cv,
    // [74:60] invert_cv, [89:75] trigger_cv, [104:90] reset_cv, rest zero
    input  wire logic [S_DATA_W-1:0]    s_tdata,
    // [0] comparator_plugged
    input  wire logic                   s_tuser,
    // result channel
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [0] up_gate, [1] down_gate, [16:2] stepper_out, [20:17] bar_level, rest zero
    output logic [M_DATA_W-1:0]         m_tdata
);

    wcs_cmd_t           cmd;
    logic               div_done;
    logic               up_gate, down_gate;
    logic signed [OUT_W-1:0] stepper_out;
    logic [LEVEL_W-1:0] bar_level;

    wcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .div_done (div_done),
        .cmd      (cmd)
    );

    wcs_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .comparator_in      (s_tdata[14:0]),
        .comparator_plugged (s_tuser),
        .bias_cv            (s_tdata[29:15]),
        .range_cv           (s_tdata[44:30]),
        .step_cv            (s_tdata[59:45]),
        .invert_cv          (s_tdata[74:60]),
        .trigger_cv         (s_tdata[89:75]),
        .reset_cv           (s_tdata[104:90]),
        .cmd                (cmd),
        .div_done           (div_done),
        .up_gate            (up_gate),
        .down_gate          (down_gate),
        .stepper_out        (stepper_out),
        .bar_level          (bar_level)
    );

    assign m_tdata = {3'b000, bar_level, stepper_out, down_gate, up_gate};

    // A request blocks further requests until it has been processed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one still in progress");

    // Bar level always within 1..10
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[20:17] >= 4'd1 && m_tdata[20:17] <= 4'd10))
        else $error("bar level out of range");

    // Held output stays within +-10 V
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[16:2]) <= 15'sd10000
                      && $signed(m_tdata[16:2]) >= -15'sd10000))
        else $error("stepper output out of range");

    // Up and down gates are exclusive
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("up and down gates both set");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import wcs_pkg::*;

    localparam int IDLE_MAX    = 19;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 255;

    // one sample set, as carried by a request
    typedef struct packed {
        logic signed [CV_W-1:0] cmp_in;
        logic                   plugged;
        logic signed [CV_W-1:0] bias_cv;
        logic signed [CV_W-1:0] range_cv;
        logic signed [CV_W-1:0] step_cv;
        logic signed [CV_W-1:0] invert_cv;
        logic signed [CV_W-1:0] trigger_cv;
        logic signed [CV_W-1:0] reset_cv;
    } cv_set_t;

    // one result
    typedef struct packed {
        logic                    up;
        logic                    dn;
        logic signed [OUT_W-1:0] held;
        logic [LEVEL_W-1:0]      level;
    } stepper_res_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // predictor state: knobs and stepper
    int k_bias, k_range, k_step;
    int run_val, held_val;
    bit trig_hi;

    stepper_res_t stepper_q[$];
    cv_set_t      vec_cv[$];
    bit           vec_typed[$];
    stepper_res_t vec_res[$];

    int err_count = 0;
    int cycle_cnt = 0;
    bit tx_no_gap   = 1'b0;
    bit rx_no_stall = 1'b0;
    bit hold_req    = 1'b0;

    always #4 aclk = ~aclk;

    window_comparator_stepper u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    function automatic int clip(input int x, input int lo, input int hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // window gates, trigger/reset stepper update and bar level for one request
    function automatic stepper_res_t advance_stepper(input cv_set_t v);
        int bias, rng, cv5, stp, cval, corr, n;
        stepper_res_t r;
        bias = clip(k_bias + int'(v.bias_cv), -10000, 10000);
        rng  = k_range + int'(v.range_cv);
        if (rng < 0) rng = -rng;
        rng  = clip(rng, 0, 10000);
        // step_cv / 5, rounded to nearest, numerator kept positive
        cv5  = (2 * int'(v.step_cv) + 40005) / 10 - 4000;
        stp  = clip(k_step + cv5, -5000, 5000);
        if (v.invert_cv > 0) stp = -stp;

        cval = v.plugged ? int'(v.cmp_in) : run_val;
        r.up = 1'b0;
        r.dn = 1'b0;
        corr = 0;
        if (2 * cval >= 2 * bias + rng) begin
            r.up = 1'b1;
            corr = -rng;
        end else if (2 * cval <= 2 * bias - rng) begin
            r.dn = 1'b1;
            corr = rng;
        end
        if (v.plugged) corr = 0;

        if (!trig_hi && v.trigger_cv > TRIG_ON) begin
            trig_hi  = 1'b1;
            run_val  = clip(run_val + ((corr == 0) ? stp : corr), -10000, 10000);
            held_val = run_val;
        end else if (trig_hi && v.trigger_cv < TRIG_OFF) begin
            trig_hi = 1'b0;
        end

        if (v.reset_cv >= RST_ON) begin
            held_val = bias;
            run_val  = v.plugged ? 0 : bias;
        end else if (!trig_hi) begin
            held_val = run_val;
        end

        n = 2 * (run_val - bias) + rng;
        if (rng == 0)
            r.level = (n > 0) ? LEVEL_MAX : LEVEL_MIN;
        else if (n <= 0)
            r.level = LEVEL_MIN;
        else
            r.level = LEVEL_W'(clip((11 * n) / (2 * rng), 1, 10));
        r.held = OUT_W'(held_val);
        return r;
    endfunction

    // one row of the directed table; typed rows carry their own result
    task automatic add_vec(input int cmp, input int plg, input int bc, input int rc,
                           input int sc, input int ic, input int tc, input int xc,
                           input bit typed = 1'b0, input int up = 0, input int dn = 0,
                           input int held = 0, input int lvl = 0);
        cv_set_t v;
        stepper_res_t r;
        v.cmp_in     = CV_W'(cmp);
        v.plugged    = plg[0];
        v.bias_cv    = CV_W'(bc);
        v.range_cv   = CV_W'(rc);
        v.step_cv    = CV_W'(sc);
        v.invert_cv  = CV_W'(ic);
        v.trigger_cv = CV_W'(tc);
        v.reset_cv   = CV_W'(xc);
        r.up         = up[0];
        r.dn         = dn[0];
        r.held       = OUT_W'(held);
        r.level      = LEVEL_W'(lvl);
        vec_cv.push_back(v);
        vec_typed.push_back(typed);
        vec_res.push_back(r);
    endtask

    // mostly in-range voltages, some threshold values, some raw bit patterns
    function automatic logic signed [CV_W-1:0] pick_cv();
        int sel;
        int specials[9] = '{0, -1, 99, 100, 999, 1000, 1001, 12000, -12000};
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return CV_W'($urandom);
        else if (sel == 1)
            return CV_W'(specials[$urandom_range(0, 8)]);
        else
            return CV_W'(int'($urandom_range(0, 24000)) - 12000);
    endfunction

    // random request shaped so trigger edges and window crossings happen often
    function automatic cv_set_t random_cv();
        cv_set_t v;
        int sel;
        v.cmp_in    = pick_cv();
        v.plugged   = 1'($urandom_range(0, 1));
        v.bias_cv   = pick_cv();
        v.step_cv   = pick_cv();
        v.invert_cv = pick_cv();
        sel = $urandom_range(0, 19);
        if (sel < 2)
            v.range_cv = CV_W'(-k_range);          // window collapses to zero
        else if (sel == 2)
            v.range_cv = CV_W'(-2 * k_range);      // negative sum, made absolute
        else
            v.range_cv = pick_cv();
        sel = $urandom_range(0, 9);
        if (sel < 4)
            v.trigger_cv = CV_W'(int'($urandom_range(0, 2099)) - 2000);
        else if (sel < 8)
            v.trigger_cv = CV_W'($urandom_range(1001, 12000));
        else if (sel == 8)
            v.trigger_cv = CV_W'($urandom_range(100, 1000));
        else
            v.trigger_cv = pick_cv();
        sel = $urandom_range(0, 19);
        if (sel < 17)
            v.reset_cv = CV_W'(int'($urandom_range(0, 12999)) - 12000);
        else if (sel < 19)
            v.reset_cv = CV_W'($urandom_range(1000, 12000));
        else
            v.reset_cv = pick_cv();
        return v;
    endfunction

    // offer one request after a random gap, predict on acceptance
    task automatic send_item(input cv_set_t v, input bit typed, input stepper_res_t want);
        int gap;
        stepper_res_t pred;
        gap = tx_no_gap ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - 7 * CV_W){1'b0}}, v.reset_cv, v.trigger_cv, v.invert_cv,
                     v.step_cv, v.range_cv, v.bias_cv, v.cmp_in};
        s_tuser  <= v.plugged;
        do @(posedge aclk); while (!s_tready);
        pred = advance_stepper(v);
        stepper_q.push_back(typed ? want : pred);
    endtask

    // stop offering until every expected result is out
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (stepper_q.size() != 0);
    endtask

    // write all three knobs on consecutive cycles, block idle
    task automatic write_knobs(input logic [CFG_W-1:0] b, input logic [CFG_W-1:0] r,
                               input logic [CFG_W-1:0] s);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_BIAS_KNOB;
        cfg_wdata <= b;
        k_bias = int'($signed(b));
        @(posedge aclk);
        cfg_addr  <= REG_RANGE_KNOB;
        cfg_wdata <= r;
        k_range = int'(r);
        @(posedge aclk);
        cfg_addr  <= REG_STEP_KNOB;
        cfg_wdata <= s;
        k_step = int'($signed(s[STEP_K_W-1:0]));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    endtask

    // result check
    always @(posedge aclk) begin
        stepper_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (stepper_q.size() == 0) begin
                report_mismatch("result with none pending", int'(m_tdata), 0);
            end else begin
                want = stepper_q.pop_front();
                if (m_tdata[0] !== want.up)
                    report_mismatch("up_gate", int'(m_tdata[0]), int'(want.up));
                if (m_tdata[1] !== want.dn)
                    report_mismatch("down_gate", int'(m_tdata[1]), int'(want.dn));
                if (m_tdata[16:2] !== want.held)
                    report_mismatch("stepper_out", int'($signed(m_tdata[16:2])),
                                    int'(want.held));
                if (m_tdata[20:17] !== want.level)
                    report_mismatch("bar_level", int'(m_tdata[20:17]), int'(want.level));
            end
        end
    end

    // result side: random stalls, with a long hold-off on request
    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                for (stall = 0; stall < HOLD_CYCLES; stall++) @(posedge aclk);
            end else begin
                stall = rx_no_stall ? 0 : $urandom_range(0, IDLE_MAX);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("window_comparator_stepper test failed");
        $finish;
    end

    // stimulus
    initial begin
        stepper_res_t none;
        none = '0;
        k_bias   = int'(BIAS_KNOB_RST);
        k_range  = int'(RANGE_KNOB_RST);
        k_step   = int'(STEP_KNOB_RST);
        run_val  = int'(RV_RST);
        held_val = 0;
        trig_hi  = 1'b0;

        // directed table, reset knobs
        //      cmp     plg bias_cv range_cv step_cv inv     trig    reset
        add_vec(0,      0,  0,      0,       0,      0,      0,      0,
                1'b1, 0, 0, 1000, 5);                          // state after reset
        add_vec(0,      0,  0,      0,       0,      0,      1001,   0);     // first edge
        add_vec(0,      0,  0,      0,       0,      0,      1000,   0);     // still high
        add_vec(0,      0,  0,      0,       0,      0,      100,    0);     // not released
        add_vec(0,      0,  0,      0,       0,      0,      99,     0);     // released
        add_vec(0,      0,  0,      0,       12000,  1,      1001,   0);     // inverted step
        add_vec(0,      0,  0,      0,       0,      0,      0,      0);
        add_vec(0,      0,  0,      0,       -12000, -16384, 16383,  0);     // raw extremes
        add_vec(0,      0,  0,      0,       0,      0,      -16384, 0);
        add_vec(16383,  1,  0,      0,       0,      0,      0,      0);     // plugged, up
        add_vec(-16384, 1,  0,      0,       0,      0,      0,      0);     // plugged, down
        add_vec(0,      0,  0,      -3000,   0,      0,      1001,   0);     // zero range
        add_vec(0,      0,  0,      -6000,   0,      0,      0,      0);     // abs range
        add_vec(0,      0,  0,      16383,   0,      0,      0,      0);     // range clamp
        add_vec(0,      0,  16383,  0,       0,      0,      0,      0);     // bias clamp hi
        add_vec(0,      0,  -16384, 0,       0,      0,      0,      0);     // bias clamp lo
        add_vec(0,      0,  0,      0,       0,      0,      0,      999);   // no reset
        add_vec(0,      0,  0,      0,       0,      0,      1001,   1000);  // reset wins
        add_vec(0,      1,  0,      0,       0,      0,      0,      16383,
                1'b1, 0, 0, 1000, 1);                          // plugged reset
        add_vec(0,      0,  -5000,  0,       0,      0,      0,      0);
        add_vec(0,      0,  -5000,  0,       0,      0,      1001,   0);     // -range fix
        add_vec(0,      0,  0,      0,       0,      0,      0,      0);
        add_vec(0,      0,  6000,   0,       0,      0,      1001,   0);     // +range fix
        add_vec(16383,  1,  0,      0,       0,      0,      0,      0);
        add_vec(16383,  1,  0,      0,       0,      0,      1001,   0);     // plugged edge

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (vec_cv[i])
            send_item(vec_cv[i], vec_typed[i], vec_res[i]);

        // random phases, each under its own knob setting
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain();
                case (p)
                    1: write_knobs(CFG_W'(-5000), CFG_W'(0), CFG_W'(-1000));
                    2: write_knobs(CFG_W'(5000), CFG_W'(10000), CFG_W'(1000));
                    3: write_knobs(14'h2000, 14'h3FFF, 14'h3C00);
                    4: write_knobs(CFG_W'(int'($urandom_range(0, 10000)) - 5000),
                                   CFG_W'($urandom_range(0, 10000)),
                                   CFG_W'(int'($urandom_range(0, 2000)) - 1000));
                    default: write_knobs(CFG_W'($urandom), CFG_W'($urandom),
                                         CFG_W'($urandom));
                endcase
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 50 == 0) begin
                    tx_no_gap   = ($urandom_range(0, 3) == 0);
                    rx_no_stall = ($urandom_range(0, 3) == 0);
                end
                // long result hold-off while requests keep coming
                if (i == 20 && p % 2 == 1) begin
                    hold_req  = 1'b1;
                    tx_no_gap = 1'b1;
                end
                if (i == PHASE_ITEMS / 2)
                    drain();
                send_item(random_cv(), 1'b0, none);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("window_comparator_stepper test passed");
        else
            $display("window_comparator_stepper test failed");
        $finish;
    end

endmodule
